// ===== sv/aesctr_pkg.sv =====
package aesctr_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned RndW      = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0  = 3'd0,
    CfgKey1  = 3'd1,
    CfgKey2  = 3'd2,
    CfgKey3  = 3'd3,
    CfgIvUp  = 3'd4,
    CfgIvLow = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits 127-8i downward
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[k + 4*c] = SBOX[s[127 - 8*(k + 4*((c + k) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127 - 32*c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                               a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/aesctr_if.sv =====
interface aesctr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic [4:0]  valid_bytes;
  logic        restart;
  modport source (output valid, data_hi, data_lo, valid_bytes, restart, input ready);
  modport sink (input valid, data_hi, data_lo, valid_bytes, restart, output ready);
endinterface

interface aesctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  modport source (output valid, cipher_hi, cipher_lo, input ready);
  modport sink (input valid, cipher_hi, cipher_lo, output ready);
endinterface

// ===== sv/aes256_counter_mode_encrypt.sv =====
// an accepted word is loaded, run through the rounds and handed to the output as its result word
// a new word is taken only after the last result is handed off, as all rounds share the single aes round unit
//   (one load step, 14 round steps, one hand-off step)
// round keys are generated on the fly by the same sequencer, no expansion delay
// reset: async active low, key and iv cleared, counter set to iv || 1
module aes256_counter_mode_encrypt import aesctr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  aesctr_in_if.sink           in_i,
  aesctr_out_if.source        out_o
);

  typedef enum logic [1:0] {Idle, Run, Done} state_e;

  state_e         state_q;
  logic [255:0]   key_q;
  logic [95:0]    iv_q;
  logic [127:0]   ctr_q, ctr_d, ctr_base;
  logic [127:0]   blk_q, data_q, mask_q, mask_d;
  logic [255:0]   win_q;
  logic [RndW-1:0] rnd_q;
  logic [31:0]    nw0, nw1, nw2, nw3, tw;
  logic [127:0]   rk, rnd_out;
  logic [4:0]     vb;
  logic           out_valid_q;
  logic [127:0]   out_q;

  assign ctr_base = in_i.restart ? {iv_q, 32'd1} : ctr_q;
  assign ctr_d    = ctr_base + 128'd1;

  always_comb begin
    vb = (in_i.valid_bytes > 5'd16) ? 5'd16 : in_i.valid_bytes;
    for (int i = 0; i < 16; i++) begin
      mask_d[127 - 8*i -: 8] = (5'(i) < vb) ? 8'hff : 8'h00;
    end
  end

  // next four round-key words from the eight-word window
  always_comb begin
    if (!rnd_q[0]) begin
      tw = sub_word({win_q[31:0]} << 8 | {win_q[31:0]} >> 24)
           ^ {8'h01 << ((rnd_q >> 1) - 4'd1), 24'd0};
    end else begin
      tw = sub_word(win_q[31:0]);
    end
    nw0 = win_q[255:224] ^ tw;
    nw1 = win_q[223:192] ^ nw0;
    nw2 = win_q[191:160] ^ nw1;
    nw3 = win_q[159:128] ^ nw2;
    rk  = (rnd_q == RndW'(1)) ? win_q[127:0] : {nw0, nw1, nw2, nw3};
  end

  assign rnd_out = aes_round(blk_q, rnd_q == RndW'(NumRounds)) ^ rk;

  assign in_i.ready    = (state_q == Idle) && !cfg_we_i;
  assign out_o.valid   = out_valid_q;
  assign out_o.cipher_hi = out_q[127:64];
  assign out_o.cipher_lo = out_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      key_q       <= '0;
      iv_q        <= '0;
      ctr_q       <= 128'd1;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      blk_q       <= '0;
      data_q      <= '0;
      mask_q      <= '0;
      win_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != Done)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKey0:  key_q[255:192] <= cfg_wdata_i;
          CfgKey1:  key_q[191:128] <= cfg_wdata_i;
          CfgKey2:  key_q[127:64]  <= cfg_wdata_i;
          CfgKey3:  key_q[63:0]    <= cfg_wdata_i;
          CfgIvUp: begin
            iv_q[95:32] <= cfg_wdata_i;
            ctr_q       <= {cfg_wdata_i, iv_q[31:0], 32'd1};
          end
          CfgIvLow: begin
            iv_q[31:0] <= cfg_wdata_i[31:0];
            ctr_q      <= {iv_q[95:32], cfg_wdata_i[31:0], 32'd1};
          end
          default: ;
        endcase
      end
      case (state_q)
        Idle: begin
          if (in_i.valid && !cfg_we_i) begin
            ctr_q   <= ctr_d;
            blk_q   <= ctr_d ^ key_q[255:128];
            win_q   <= key_q;
            data_q  <= {in_i.data_hi, in_i.data_lo};
            mask_q  <= mask_d;
            rnd_q   <= RndW'(1);
            state_q <= Run;
          end
        end
        Run: begin
          blk_q <= rnd_out;
          if (rnd_q != RndW'(1)) begin
            win_q <= {win_q[127:0], nw0, nw1, nw2, nw3};
          end
          rnd_q <= rnd_q + RndW'(1);
          if (rnd_q == RndW'(NumRounds)) begin
            state_q <= Done;
          end
        end
        Done: begin
          if (!out_valid_q || out_o.ready) begin
            out_q       <= (blk_q ^ data_q) & mask_q;
            out_valid_q <= 1'b1;
            state_q     <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule

// ===== sv/aesctr_checker.sv =====
module aesctr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] cipher_hi
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cipher_hi))
    else $error("output word dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared right after accept");

  a_busy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ##8 !in_ready)
    else $error("round sequence ended too soon");

endmodule

bind aes256_counter_mode_encrypt aesctr_checker u_aesctr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .cipher_hi (out_o.cipher_hi)
);
